[rtl/csvp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CSV parser package
// Shared types, result kinds, register indexes and character constants.
// ----------------------------------------------------------------------------
package csvp_pkg;

    localparam int BYTE_W   = 8;
    localparam int KIND_W   = 3;
    localparam int SLOTS    = 4;
    localparam int SLOT_W   = $clog2(SLOTS);
    localparam int Q_DEPTH  = 4;
    localparam int Q_PTR_W  = $clog2(Q_DEPTH);
    localparam int Q_CNT_W  = $clog2(Q_DEPTH + 1);

    localparam logic [BYTE_W-1:0] CH_CR          = 8'd13;
    localparam logic [BYTE_W-1:0] CH_LF          = 8'd10;
    localparam logic [BYTE_W-1:0] DELIMITER_INIT = 8'd44;
    localparam logic [BYTE_W-1:0] QUOTE_INIT     = 8'd34;

    localparam logic REG_DELIMITER = 1'b0;
    localparam logic REG_QUOTE     = 1'b1;

    typedef enum logic [KIND_W-1:0] {
        KIND_BYTE = 3'd0,
        KIND_EOC  = 3'd1,
        KIND_EOR  = 3'd2,
        KIND_ERR  = 3'd3,
        KIND_DONE = 3'd4
    } kind_t;

    // One queue entry: the results caused by one accepted byte, in order.
    typedef struct packed {
        logic [SLOTS-1:0][KIND_W-1:0] kinds;
        logic [SLOT_W-1:0]            last_idx;
        logic [BYTE_W-1:0]            data;
    } entry_t;

    typedef struct packed {
        logic   valid;
        entry_t entry;
    } push_t;

endpackage

[rtl/csv_byte_stream_parser.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// CSV byte stream parser
// Parses CSV text one byte per transfer into cell bytes and cell, row, error
// and done markers, with programmable delimiter and quote bytes.
// ----------------------------------------------------------------------------
//  Channel   Direction  Content
//  s_axis    in         tdata = in_byte, tlast = end_of_text
//  m_axis    out        tdata = cell_byte, tuser = kind, tlast = last_of_run
//  cfg       in         cfg_index 0 delimiter, 1 quote; cfg_data = value
//
// Each input byte is classified and its next phase computed combinationally, so
// bytes are taken every cycle while the four-entry bundle queue has room.
// The output stage sends one result per cycle while m_axis_tready is high; a
// byte yields at most four results, and four only at end of text.
// Reset returns the phase to line start and the registers to comma and
// double quote. Input and output stall independently through the queue.
// ----------------------------------------------------------------------------
module csv_byte_stream_parser (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [7:0]   s_axis_tdata,   // [7:0] in_byte
    input  wire logic         s_axis_tlast,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [7:0]        m_axis_tdata,   // [7:0] cell_byte
    output logic [2:0]        m_axis_tuser,   // [2:0] kind
    output logic              m_axis_tlast,
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic         cfg_index,
    input  wire logic [7:0]   cfg_data
);

    csvp_pkg::push_t    push;
    csvp_pkg::entry_t   head;
    csvp_pkg::kind_t    out_kind;
    logic               q_full;
    logic               head_valid;
    logic               pop;

    assign cfg_ready = 1'b1;

    csvp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_byte   (s_axis_tdata),
        .in_last   (s_axis_tlast),
        .q_full    (q_full),
        .push      (push)
    );

    csvp_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (q_full),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop)
    );

    csvp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_kind   (out_kind),
        .out_byte   (m_axis_tdata),
        .out_last   (m_axis_tlast)
    );

    assign m_axis_tuser = out_kind;

endmodule
`default_nettype wire

[rtl/csvp_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// CSV parser front end
// Holds the delimiter and quote registers, classifies each incoming byte and
// runs the parse phase machine, producing at most one result bundle per byte.
// ----------------------------------------------------------------------------
module csvp_front (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_valid,
    input  wire logic                          cfg_index,
    input  wire logic [csvp_pkg::BYTE_W-1:0]   cfg_data,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [csvp_pkg::BYTE_W-1:0]   in_byte,
    input  wire logic                          in_last,
    input  wire logic                          q_full,
    output csvp_pkg::push_t                    push
);

    typedef enum logic [5:0] {
        PH_LINE   = 6'b000001,
        PH_CELL   = 6'b000010,
        PH_PLAIN  = 6'b000100,
        PH_QUOTED = 6'b001000,
        PH_QSEEN  = 6'b010000,
        PH_ERROR  = 6'b100000
    } phase_t;

    phase_t                                   phase_reg;
    phase_t                                   phase_next;
    phase_t                                   ph;
    logic [csvp_pkg::BYTE_W-1:0]              delim_reg;
    logic [csvp_pkg::BYTE_W-1:0]              quote_reg;
    logic                                     is_quote;
    logic                                     is_delim;
    logic                                     is_eol;
    logic                                     accept;
    logic [csvp_pkg::SLOT_W:0]                n;
    logic [csvp_pkg::SLOTS-1:0][csvp_pkg::KIND_W-1:0] kinds;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    assign is_quote = (in_byte == quote_reg);
    assign is_delim = (in_byte == delim_reg) && !is_quote;
    assign is_eol   = ((in_byte == csvp_pkg::CH_CR) || (in_byte == csvp_pkg::CH_LF))
                      && !is_quote && !is_delim;

    always_comb
    begin
        kinds = '0;
        n     = '0;
        ph    = phase_reg;
        unique case (phase_reg)
            PH_PLAIN:
            begin
                if (is_quote)
                begin
                    kinds[n[csvp_pkg::SLOT_W-1:0]] = csvp_pkg::KIND_ERR;
                    n  = n + 1'b1;
                    ph = PH_ERROR;
                end
                else if (is_delim)
                begin
                    kinds[n[csvp_pkg::SLOT_W-1:0]] = csvp_pkg::KIND_EOC;
                    n  = n + 1'b1;
                    ph = PH_CELL;
                end
                else if (is_eol)
                begin
                    kinds[n[csvp_pkg::SLOT_W-1:0]] = csvp_pkg::KIND_EOC;
                    n  = n + 1'b1;
                    kinds[n[csvp_pkg::SLOT_W-1:0]] = csvp_pkg::KIND_EOR;
                    n  = n + 1'b1;
                    ph = PH_LINE;
                end
                else
                begin
                    kinds[n[csvp_pkg::SLOT_W-1:0]] = csvp_pkg::KIND_BYTE;
                    n  = n + 1'b1;
                end
            end
            PH_QUOTED:
            begin
                if (is_quote)
                begin
                    ph = PH_QSEEN;
                end
                else
                begin
                    kinds[n[csvp_pkg::SLOT_W-1:0]] = csvp_pkg::KIND_BYTE;
                    n  = n + 1'b1;
                end
            end
            PH_QSEEN:
            begin
                if (is_quote)
                begin
                    kinds[n[csvp_pkg::SLOT_W-1:0]] = csvp_pkg::KIND_BYTE;
                    n  = n + 1'b1;
                    ph = PH_QUOTED;
                end
                else if (is_delim)
                begin
                    kinds[n[csvp_pkg::SLOT_W-1:0]] = csvp_pkg::KIND_EOC;
                    n  = n + 1'b1;
                    ph = PH_CELL;
                end
                else if (is_eol)
                begin
                    kinds[n[csvp_pkg::SLOT_W-1:0]] = csvp_pkg::KIND_EOC;
                    n  = n + 1'b1;
                    kinds[n[csvp_pkg::SLOT_W-1:0]] = csvp_pkg::KIND_EOR;
                    n  = n + 1'b1;
                    ph = PH_LINE;
                end
                else
                begin
                    kinds[n[csvp_pkg::SLOT_W-1:0]] = csvp_pkg::KIND_ERR;
                    n  = n + 1'b1;
                    ph = PH_ERROR;
                end
            end
            PH_ERROR:
            begin
                ph = PH_ERROR;
            end
            default:
            begin
                // Line start and cell start, which differ only on a line end.
                if (is_quote)
                begin
                    ph = PH_QUOTED;
                end
                else if (is_delim)
                begin
                    kinds[n[csvp_pkg::SLOT_W-1:0]] = csvp_pkg::KIND_EOC;
                    n  = n + 1'b1;
                    ph = PH_CELL;
                end
                else if (is_eol)
                begin
                    if (phase_reg == PH_CELL)
                    begin
                        kinds[n[csvp_pkg::SLOT_W-1:0]] = csvp_pkg::KIND_EOC;
                        n = n + 1'b1;
                        kinds[n[csvp_pkg::SLOT_W-1:0]] = csvp_pkg::KIND_EOR;
                        n = n + 1'b1;
                    end
                    ph = PH_LINE;
                end
                else
                begin
                    kinds[n[csvp_pkg::SLOT_W-1:0]] = csvp_pkg::KIND_BYTE;
                    n  = n + 1'b1;
                    ph = PH_PLAIN;
                end
            end
        endcase

        if (in_last)
        begin
            if ((ph == PH_CELL) || (ph == PH_PLAIN) || (ph == PH_QSEEN))
            begin
                kinds[n[csvp_pkg::SLOT_W-1:0]] = csvp_pkg::KIND_EOC;
                n = n + 1'b1;
                kinds[n[csvp_pkg::SLOT_W-1:0]] = csvp_pkg::KIND_EOR;
                n = n + 1'b1;
            end
            else if (ph == PH_QUOTED)
            begin
                kinds[n[csvp_pkg::SLOT_W-1:0]] = csvp_pkg::KIND_ERR;
                n = n + 1'b1;
            end
            kinds[n[csvp_pkg::SLOT_W-1:0]] = csvp_pkg::KIND_DONE;
            n  = n + 1'b1;
            ph = PH_LINE;
        end
    end

    assign phase_next = accept ? ph : phase_reg;

    always_comb
    begin
        push.valid          = accept && (n != '0);
        push.entry.kinds    = kinds;
        push.entry.last_idx = csvp_pkg::SLOT_W'(n - 1'b1);
        push.entry.data     = in_byte;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_LINE;
            delim_reg <= csvp_pkg::DELIMITER_INIT;
            quote_reg <= csvp_pkg::QUOTE_INIT;
        end
        else
        begin
            phase_reg <= phase_next;
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    csvp_pkg::REG_DELIMITER: delim_reg <= cfg_data;
                    csvp_pkg::REG_QUOTE:     quote_reg <= cfg_data;
                    default:                 delim_reg <= delim_reg;
                endcase
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_eot_returns_to_line: assert property (@(posedge clk) disable iff (!rst_n)
        accept && in_last |=> phase_reg == PH_LINE)
        else $error("phase not at line start after end of text");

    a_eot_always_pushes: assert property (@(posedge clk) disable iff (!rst_n)
        accept && in_last |-> push.valid)
        else $error("end of text produced no results");
`endif

endmodule
`default_nettype wire

[rtl/csvp_fifo.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// CSV parser bundle queue
// Short queue of result bundles between the front end and the output side.
// ----------------------------------------------------------------------------
module csvp_fifo (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire csvp_pkg::push_t   push,
    output logic                   full,
    output logic                   head_valid,
    output csvp_pkg::entry_t       head,
    input  wire logic              pop
);

    csvp_pkg::entry_t                 store_reg [csvp_pkg::Q_DEPTH];
    logic [csvp_pkg::Q_PTR_W-1:0]     wr_ptr_reg;
    logic [csvp_pkg::Q_PTR_W-1:0]     wr_ptr_next;
    logic [csvp_pkg::Q_PTR_W-1:0]     rd_ptr_reg;
    logic [csvp_pkg::Q_PTR_W-1:0]     rd_ptr_next;
    logic [csvp_pkg::Q_CNT_W-1:0]     count_reg;
    logic [csvp_pkg::Q_CNT_W-1:0]     count_next;
    logic                             do_push;
    logic                             do_pop;

    assign full       = (count_reg == csvp_pkg::Q_CNT_W'(csvp_pkg::Q_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = store_reg[rd_ptr_reg];

    assign do_push = push.valid && !full;
    assign do_pop  = pop && head_valid;

    assign wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
    assign rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            store_reg[wr_ptr_reg] <= push.entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push.valid |-> !full)
        else $error("bundle pushed into a full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("bundle popped from an empty queue");
`endif

endmodule
`default_nettype wire

[rtl/csvp_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// CSV parser output side
// Walks the results of each queued bundle and presents them one per transfer
// through a registered output stage.
// ----------------------------------------------------------------------------
module csvp_back (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          head_valid,
    input  wire csvp_pkg::entry_t              head,
    output logic                               pop,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output csvp_pkg::kind_t                    out_kind,
    output logic [csvp_pkg::BYTE_W-1:0]        out_byte,
    output logic                               out_last
);

    logic [csvp_pkg::SLOT_W-1:0]    idx_reg;
    logic [csvp_pkg::SLOT_W-1:0]    idx_next;
    logic                           valid_reg;
    logic                           valid_next;
    csvp_pkg::kind_t                kind_reg;
    csvp_pkg::kind_t                slot_kind;
    logic [csvp_pkg::BYTE_W-1:0]    byte_reg;
    logic                           last_reg;
    logic                           load;
    logic                           slot_last;

    assign load      = head_valid && (!valid_reg || out_ready);
    assign slot_kind = csvp_pkg::kind_t'(head.kinds[idx_reg]);
    assign slot_last = (idx_reg == head.last_idx);
    assign pop       = load && slot_last;

    assign idx_next   = load ? (slot_last ? '0 : idx_reg + 1'b1) : idx_reg;
    assign valid_next = load ? 1'b1 : (valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            kind_reg <= slot_kind;
            byte_reg <= (slot_kind == csvp_pkg::KIND_BYTE) ? head.data : '0;
            last_reg <= slot_last;
        end
    end

    assign out_valid = valid_reg;
    assign out_kind  = kind_reg;
    assign out_byte  = byte_reg;
    assign out_last  = last_reg;

`ifndef NO_ASSERTIONS
    a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_kind == csvp_pkg::KIND_DONE) |-> out_last)
        else $error("text done result not marked last of run");

    a_walk_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> idx_reg == '0)
        else $error("slot index not reset after bundle completed");
`endif

endmodule
`default_nettype wire
